FILE: rtl/pvx_pkg.sv
`timescale 1ns / 1ps
package pvx_pkg;

  localparam int unsigned LenBitsDflt = 24;
  localparam int unsigned MinLenDflt  = 188;
  localparam int unsigned CfgW        = 24;
  localparam int unsigned CountW      = 24;
  localparam int unsigned RemW        = 16;
  localparam int unsigned FifoDepth   = 4;

  localparam logic [1:0] ClassVideo = 2'd0;
  localparam logic [1:0] ClassTs    = 2'd1;
  localparam logic [1:0] ClassOther = 2'd2;
  localparam logic [1:0] ClassShort = 2'd3;

  localparam logic [7:0] TsSync      = 8'h47;
  localparam logic [7:0] StuffByte   = 8'hFF;
  localparam logic [7:0] OtherIdLow  = 8'hBD;
  localparam logic [7:0] OtherIdHigh = 8'hDF;
  localparam logic [3:0] VideoIdHi   = 4'hE;
  localparam logic [1:0] Mpeg2Mark   = 2'b10;
  localparam logic [1:0] StdMark     = 2'b01;
  localparam logic [3:0] PtsMark     = 4'h2;
  localparam logic [3:0] PtsDtsMark  = 4'h3;

  typedef enum logic [3:0] {
    PH_SCAN       = 4'd0,
    PH_ID         = 4'd1,
    PH_LEN_HI     = 4'd2,
    PH_LEN_LO     = 4'd3,
    PH_SKIP_OTHER = 4'd4,
    PH_HDR_FIRST  = 4'd5,
    PH_M2_FLAGS   = 4'd6,
    PH_M2_HLEN    = 4'd7,
    PH_HDR_SKIP   = 4'd8,
    PH_M1_STUFF   = 4'd9,
    PH_M1_STD2    = 4'd10,
    PH_M1_PTS     = 4'd11,
    PH_PAYLOAD    = 4'd12
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       picture_start;
  } pvx_in_t;

  typedef struct packed {
    logic              is_summary;
    logic [7:0]        payload_byte;
    logic              packet_end;
    logic [1:0]        picture_class;
    logic [CountW-1:0] payload_count;
    logic              stopped_early;
  } pvx_out_t;

  typedef struct packed {
    logic     pay_valid;
    logic     sum_valid;
    pvx_out_t pay;
    pvx_out_t sum;
  } pvx_res_t;

endpackage

FILE: rtl/pvx_parser.sv
`timescale 1ns / 1ps
module pvx_parser import pvx_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LenBitsDflt,
  parameter int unsigned MIN_LENGTH  = MinLenDflt
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  pvx_in_t         in_i,
  input  logic [CfgW-1:0] total_length_i,
  output pvx_res_t        res_o
);

  localparam int unsigned LW = LENGTH_BITS;
  localparam int unsigned AW = LW + 1;

  logic [LW-1:0]   pos_q, pos_d;
  logic [15:0]     rb_q, rb_d;
  parse_phase_e    ph_q, ph_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [7:0]      skip_q, skip_d;
  logic            vid_q, vid_d;
  logic [LW-1:0]   em_d, em_q;
  logic [1:0]      cls_q, cls_d;
  logic            halt_q, halt_d;
  logic [1:0]      fill_q, fill_d;

  logic [LW-1:0] len;
  assign len = LW'({8'h00, total_length_i});

  pvx_res_t res;

  always_comb begin
    logic [LW-1:0]   p;
    logic [15:0]     rb_cur;
    logic [7:0]      b;
    logic            do_stuff, do_pts, bb_go, scan_now, scan_after;
    logic [RemW-1:0] bb_len;
    logic [7:0]      bb_skip;
    logic [AW-1:0]   px, lx;
    pos_d  = pos_q;
    rb_d   = rb_q;
    ph_d   = ph_q;
    rem_d  = rem_q;
    skip_d = skip_q;
    vid_d  = vid_q;
    em_d   = em_q;
    cls_d  = cls_q;
    halt_d = halt_q;
    fill_d = fill_q;
    b      = in_i.in_byte;
    if (in_i.picture_start) begin
      pos_d  = '0;
      rb_d   = '0;
      ph_d   = PH_SCAN;
      rem_d  = '0;
      skip_d = '0;
      vid_d  = 1'b0;
      em_d   = '0;
      cls_d  = ClassVideo;
      halt_d = 1'b0;
      fill_d = '0;
    end
    p          = pos_d;
    rb_cur     = rb_d;
    px         = AW'(p);
    lx         = AW'(len);
    do_stuff   = 1'b0;
    do_pts     = 1'b0;
    bb_go      = 1'b0;
    bb_len     = '0;
    bb_skip    = '0;
    scan_now   = 1'b0;
    scan_after = 1'b0;
    res        = '0;
    if (p < len) begin
      pos_d = p + 1'b1;
      if (!halt_d) begin
        rb_d = {rb_cur[7:0], b};
        if (p == '0) begin
          if (32'(len) < 32'(MIN_LENGTH)) begin
            cls_d  = ClassShort;
            halt_d = 1'b1;
          end else if (b == TsSync) begin
            cls_d  = ClassTs;
            halt_d = 1'b1;
          end else if (b != 8'h00) begin
            cls_d  = ClassOther;
            halt_d = 1'b1;
          end
        end else if (p <= LW'(2)) begin
          if (b != ((p == LW'(2)) ? 8'h01 : 8'h00)) begin
            cls_d  = ClassOther;
            halt_d = 1'b1;
          end
        end else if (p == LW'(3) && b[7:4] != VideoIdHi) begin
          cls_d  = ClassOther;
          halt_d = 1'b1;
        end
        if (!halt_d) begin
          case (ph_d)
            PH_ID: begin
              if (b[7:4] == VideoIdHi) begin
                vid_d = 1'b1;
                ph_d  = PH_LEN_HI;
              end else if (b >= OtherIdLow && b <= OtherIdHigh) begin
                vid_d = 1'b0;
                ph_d  = PH_LEN_HI;
              end else begin
                ph_d = PH_SCAN;
              end
            end
            PH_LEN_HI: begin
              rem_d = {b, 8'h00};
              ph_d  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              rem_d = {rem_d[15:8], b};
              if (vid_d) begin
                ph_d = PH_HDR_FIRST;
              end else if (rem_d == '0) begin
                ph_d   = PH_SCAN;
                fill_d = '0;
              end else begin
                ph_d = PH_SKIP_OTHER;
              end
            end
            PH_SKIP_OTHER: begin
              if (rem_d != '0) rem_d = rem_d - 1'b1;
              if (rem_d == '0) begin
                ph_d   = PH_SCAN;
                fill_d = '0;
              end
            end
            PH_HDR_FIRST: begin
              if (b[7:6] == Mpeg2Mark) ph_d = PH_M2_FLAGS;
              else do_stuff = 1'b1;
            end
            PH_M2_FLAGS: ph_d = PH_M2_HLEN;
            PH_M2_HLEN: begin
              if (LW'(b) >= len || 17'(rem_d) < 17'd3 + 17'(b) ||
                  AW'(p - LW'(2)) + AW'(rem_d) > lx) begin
                halt_d = 1'b1;
              end else begin
                bb_go   = 1'b1;
                bb_len  = rem_d - RemW'(3) - RemW'(b);
                bb_skip = b;
              end
            end
            PH_HDR_SKIP: begin
              if (skip_d != '0) skip_d = skip_d - 1'b1;
              if (skip_d == '0) begin
                if (rem_d != '0) begin
                  ph_d = PH_PAYLOAD;
                end else begin
                  ph_d   = PH_SCAN;
                  fill_d = '0;
                end
              end
            end
            PH_M1_STUFF: do_stuff = 1'b1;
            PH_M1_STD2:  ph_d = PH_M1_PTS;
            PH_M1_PTS:   do_pts = 1'b1;
            PH_PAYLOAD: begin
              if (rem_d != '0) rem_d = rem_d - 1'b1;
              em_d = em_d + 1'b1;
              if (rem_d == '0) begin
                ph_d   = PH_SCAN;
                fill_d = '0;
              end
              res.pay_valid         = 1'b1;
              res.pay.payload_byte  = b;
              res.pay.packet_end    = (rem_d == '0);
              res.pay.picture_class = cls_d;
              res.pay.payload_count = CountW'(em_d);
            end
            default: begin
              ph_d     = PH_SCAN;
              scan_now = 1'b1;
            end
          endcase

          if (do_stuff) begin
            if (rem_d != '0 && b == StuffByte) begin
              rem_d = rem_d - 1'b1;
              ph_d  = PH_M1_STUFF;
            end else if (px + AW'(2) <= lx && rem_d >= RemW'(2) && b[7:6] == StdMark) begin
              rem_d = rem_d - RemW'(2);
              ph_d  = PH_M1_STD2;
            end else begin
              do_pts = 1'b1;
            end
          end

          if (do_pts) begin
            bb_go = 1'b1;
            if (px + AW'(5) <= lx && rem_d >= RemW'(5) && b[7:4] == PtsMark) begin
              bb_len  = rem_d - RemW'(5);
              bb_skip = 8'd4;
            end else if (px + AW'(10) <= lx && rem_d >= RemW'(10) &&
                         b[7:4] == PtsDtsMark) begin
              bb_len  = rem_d - RemW'(10);
              bb_skip = 8'd9;
            end else if (rem_d != '0) begin
              bb_len = rem_d - 1'b1;
            end else begin
              scan_after = 1'b1;
            end
          end

          if (bb_go) begin
            if (AW'(em_d) + AW'(bb_len) > lx) begin
              halt_d = 1'b1;
            end else begin
              rem_d  = bb_len;
              skip_d = bb_skip;
              if (bb_skip != '0) begin
                ph_d = PH_HDR_SKIP;
              end else if (bb_len != '0) begin
                ph_d = PH_PAYLOAD;
              end else begin
                ph_d   = PH_SCAN;
                fill_d = '0;
              end
            end
          end

          if (scan_after && !halt_d) scan_now = 1'b1;

          if (scan_now) begin
            if (fill_d >= 2'd2 && rb_cur == 16'h0000 && b == 8'h01 && px + AW'(4) < lx) begin
              ph_d = PH_ID;
            end
            if (fill_d != 2'd3) fill_d = fill_d + 1'b1;
          end
        end
      end

      if (p == len - 1'b1) begin
        res.sum_valid         = 1'b1;
        res.sum.is_summary    = 1'b1;
        res.sum.picture_class = cls_d;
        res.sum.payload_count = CountW'(em_d);
        res.sum.stopped_early = (cls_d == ClassVideo) &&
          (halt_d || (ph_d inside {PH_HDR_FIRST, PH_M2_FLAGS, PH_M2_HLEN, PH_HDR_SKIP,
                                   PH_M1_STUFF, PH_M1_STD2, PH_M1_PTS}));
      end
    end
  end

  always_comb begin
    res_o           = res;
    res_o.pay_valid = res.pay_valid & go_i;
    res_o.sum_valid = res.sum_valid & go_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      rb_q   <= '0;
      ph_q   <= PH_SCAN;
      rem_q  <= '0;
      skip_q <= '0;
      vid_q  <= 1'b0;
      em_q   <= '0;
      cls_q  <= ClassVideo;
      halt_q <= 1'b0;
      fill_q <= '0;
    end else if (go_i) begin
      pos_q  <= pos_d;
      rb_q   <= rb_d;
      ph_q   <= ph_d;
      rem_q  <= rem_d;
      skip_q <= skip_d;
      vid_q  <= vid_d;
      em_q   <= em_d;
      cls_q  <= cls_d;
      halt_q <= halt_d;
      fill_q <= fill_d;
    end
  end

endmodule

FILE: rtl/pvx_out_fifo.sv
`timescale 1ns / 1ps
module pvx_out_fifo import pvx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pvx_res_t res_i,
  output logic     room_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pvx_out_t out_data_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = PtrW + 1;

  pvx_out_t        mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [1:0]      n_push;
  pvx_out_t        first;

  assign pop         = out_valid_o & ~out_stall_i;
  assign n_push      = 2'(res_i.pay_valid) + 2'(res_i.sum_valid);
  assign first       = res_i.pay_valid ? res_i.pay : res_i.sum;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign room_o      = (cnt_q <= CntW'(FifoDepth - 2));

  always_comb begin
    wr_d  = wr_q + PtrW'(n_push);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= first;
    if (n_push == 2'd2) mem_q[wr_q + 1'b1] <= res_i.sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/pes_video_payload_extractor.sv
`timescale 1ns / 1ps
// video payload extractor for still-picture buffers
// input channel: one buffer byte per request (in_valid_i / in_stall_o),
//   picture_start marks byte 0 of a new buffer and clears the parser
// config channel: cfg_valid_i / cfg_ready_o writes total_length; ready is
//   always high, write it only while no request is in flight
// output channel: out_valid_o / out_stall_i, each result either a payload
//   byte or the end-of-buffer summary; header bytes give no result
// data path: a taken byte is held in the input register; the parser's results
//   for it are registered in the output queue, which drives the output
// throughput: one byte per cycle while the output queue has room, set by the
//   parser update behind the input register; the last byte of a buffer may push two
//   results, drained by the four-entry output queue at one per cycle unless stalled
// stall: when the receiver stalls the queue fills, and once it has fewer
//   than two free entries the input stalls; nothing is dropped
// reset: total_length clears to 0, parser state and queue empty
module pes_video_payload_extractor import pvx_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LenBitsDflt,
  parameter int unsigned MIN_LENGTH  = MinLenDflt
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pvx_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pvx_out_t        out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic [CfgW-1:0] len_q;
  logic            inq_valid_q, inq_valid_d;
  pvx_in_t         inq_data_q;
  logic            room, go, take;
  pvx_res_t        res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = inq_valid_q & ~room;
  assign go          = inq_valid_q & room;
  assign take        = in_valid_i & ~in_stall_o;
  assign inq_valid_d = take | (inq_valid_q & ~go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      inq_valid_q <= 1'b0;
    end else begin
      inq_valid_q <= inq_valid_d;
      if (cfg_valid_i && cfg_ready_o) len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) inq_data_q <= in_data_i;
  end

  pvx_parser #(
    .LENGTH_BITS(LENGTH_BITS),
    .MIN_LENGTH (MIN_LENGTH)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (go),
    .in_i          (inq_data_q),
    .total_length_i(len_q),
    .res_o         (res)
  );

  pvx_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
